[hdl/stg_pkg.sv]
// ----------------------------------------------------------------------------
// stg_pkg
// Shared constants, status codes and controller/datapath interface types
// for the strided tile gather block.
// ----------------------------------------------------------------------------
package stg_pkg;

  localparam int unsigned MAX_ROWS_DEF = 64;

  // restoring divider: one quotient bit per step, one step per dividend bit
  localparam int unsigned DIV_STEPS = 17;
  localparam int unsigned DIV_CNT_W = $clog2(DIV_STEPS);

  localparam logic [16:0] SIZE_LIMIT = 17'd65536;

  localparam logic [2:0] ST_OK            = 3'd0;
  localparam logic [2:0] ST_ZERO_ROWS     = 3'd1;
  localparam logic [2:0] ST_ZERO_STRIDE   = 3'd2;
  localparam logic [2:0] ST_NOT_MULTIPLE  = 3'd3;
  localparam logic [2:0] ST_EMPTY         = 3'd4;
  localparam logic [2:0] ST_TOO_MANY_ROWS = 3'd5;
  localparam logic [2:0] ST_OVERSIZE      = 3'd6;

  typedef struct packed {
    logic load;      // capture descriptor, clear divider and row walk
    logic div_step;  // one divider iteration
    logic issue;     // load the next request into the output register
  } cmd_t;

  typedef struct packed {
    logic div_done;    // this divider step is the final one
    logic out_free;    // output register can take a request this cycle
    logic final_item;  // the request about to issue ends the descriptor
  } stat_t;

endpackage

[hdl/strided_tile_gather.sv]
// ----------------------------------------------------------------------------
// strided_tile_gather
// Read request generator for one strided 2-D tile copy.
//
// Input channel (in_*): one descriptor per request: base address, packed
// tile size, row count and row stride. in_stall is high while a descriptor
// is being worked on.
// Output channel (out_*): read requests. Contiguous tiles give one request
// for the whole size; otherwise one request per row at base + row * stride,
// with the packed offset row * row length. A bad descriptor gives a single
// error request with last set and the status code.
// Timing: a descriptor is accepted while idle, then the row length divider
// runs with one quotient bit per cycle, then one request per cycle while
// the receiver does not stall.
// The next descriptor is taken as soon as the final request sits in the
// output register. out_stall holds the output register and pauses the row
// walk. Reset empties the output register and returns the sequencer to idle.
// ----------------------------------------------------------------------------
module strided_tile_gather #(
  parameter int unsigned MAX_ROWS = stg_pkg::MAX_ROWS_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [63:0] in_base_addr,
  input  logic [16:0] in_total_bytes,
  input  logic [6:0]  in_row_count,
  input  logic [31:0] in_row_stride,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [63:0] out_read_addr,
  output logic [16:0] out_read_len,
  output logic [15:0] out_pack_offset,
  output logic        out_last,
  output logic [2:0]  out_status
);
  import stg_pkg::*;

  cmd_t  cmd;
  stat_t stat;
  logic  idle;

  stg_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .stat     (stat),
    .cmd      (cmd),
    .idle     (idle)
  );

  stg_dp #(
    .MAX_ROWS (MAX_ROWS)
  ) u_dp (
    .clk             (clk),
    .rst_n           (rst_n),
    .cmd             (cmd),
    .stat            (stat),
    .in_base_addr    (in_base_addr),
    .in_total_bytes  (in_total_bytes),
    .in_row_count    (in_row_count),
    .in_row_stride   (in_row_stride),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .out_read_addr   (out_read_addr),
    .out_read_len    (out_read_len),
    .out_pack_offset (out_pack_offset),
    .out_last        (out_last),
    .out_status      (out_status)
  );

  assign in_stall = !idle;

endmodule

[hdl/stg_ctrl.sv]
// ----------------------------------------------------------------------------
// stg_ctrl
// Sequencer: accepts a descriptor, runs the divider, then issues requests
// into the output register until the final one has been issued.
// ----------------------------------------------------------------------------
module stg_ctrl (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          in_valid,
  input  stg_pkg::stat_t stat,
  output stg_pkg::cmd_t  cmd,
  output logic          idle
);
  import stg_pkg::*;

  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_DIV  = 2'd1;
  localparam logic [1:0] S_EMIT = 2'd2;

  logic [1:0] state_r;
  logic [1:0] state_nxt;

  always_comb begin
    state_nxt    = state_r;
    cmd.load     = 1'b0;
    cmd.div_step = 1'b0;
    cmd.issue    = 1'b0;
    case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          cmd.load  = 1'b1;
          state_nxt = S_DIV;
        end
      end
      S_DIV: begin
        cmd.div_step = 1'b1;
        if (stat.div_done) begin
          state_nxt = S_EMIT;
        end
      end
      S_EMIT: begin
        if (stat.out_free) begin
          cmd.issue = 1'b1;
          if (stat.final_item) begin
            state_nxt = S_IDLE;
          end
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  assign idle = (state_r == S_IDLE);

  a_accept_starts_div: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_IDLE && in_valid) |=> state_r == S_DIV)
    else $error("accepted request did not start the divider");

  a_final_returns_idle: assert property (@(posedge clk) disable iff (!rst_n)
    (cmd.issue && stat.final_item) |=> (state_r == S_IDLE))
    else $error("controller kept issuing after the final request");

endmodule

[hdl/stg_dp.sv]
// ----------------------------------------------------------------------------
// stg_dp
// Datapath: descriptor registers, restoring divider for the row length,
// row address and pack offset accumulators, and the output register.
// ----------------------------------------------------------------------------
module stg_dp #(
  parameter int unsigned MAX_ROWS = stg_pkg::MAX_ROWS_DEF
) (
  input  logic           clk,
  input  logic           rst_n,
  input  stg_pkg::cmd_t  cmd,
  output stg_pkg::stat_t stat,
  input  logic [63:0]    in_base_addr,
  input  logic [16:0]    in_total_bytes,
  input  logic [6:0]     in_row_count,
  input  logic [31:0]    in_row_stride,
  output logic           out_valid,
  input  logic           out_stall,
  output logic [63:0]    out_read_addr,
  output logic [16:0]    out_read_len,
  output logic [15:0]    out_pack_offset,
  output logic           out_last,
  output logic [2:0]     out_status
);
  import stg_pkg::*;

  // descriptor
  logic [63:0] base_r;
  logic [16:0] total_r;
  logic [6:0]  rows_r;
  logic [31:0] stride_r;

  // divider: quot_r starts as the dividend and ends as the row length
  logic [16:0]          quot_r;
  logic [16:0]          quot_nxt;
  logic [6:0]           rem_r;
  logic [6:0]           rem_nxt;
  logic [DIV_CNT_W-1:0] div_cnt_r;
  logic [7:0]           rem_sh;
  logic [7:0]           rem_sub;
  logic                 q_bit;

  // row walk
  logic [63:0] addr_r;
  logic [15:0] off_r;
  logic [6:0]  row_r;

  logic [2:0]  err_code;
  logic        contig;
  logic        last_row;

  // output register
  logic        out_valid_r;
  logic [63:0] out_addr_r;
  logic [16:0] out_len_r;
  logic [15:0] out_off_r;
  logic        out_last_r;
  logic [2:0]  out_status_r;

  always_comb begin
    rem_sh   = {rem_r, quot_r[16]};
    rem_sub  = rem_sh - {1'b0, rows_r};
    q_bit    = (rem_sh >= {1'b0, rows_r});
    rem_nxt  = q_bit ? rem_sub[6:0] : rem_sh[6:0];
    quot_nxt = {quot_r[15:0], q_bit};
  end

  always_comb begin
    if (total_r == '0) begin
      err_code = ST_EMPTY;
    end else if (rows_r == '0) begin
      err_code = ST_ZERO_ROWS;
    end else if (stride_r == '0) begin
      err_code = ST_ZERO_STRIDE;
    end else if (rem_r != '0) begin
      err_code = ST_NOT_MULTIPLE;
    end else if (rows_r > 7'(MAX_ROWS)) begin
      err_code = ST_TOO_MANY_ROWS;
    end else if (total_r > SIZE_LIMIT) begin
      err_code = ST_OVERSIZE;
    end else begin
      err_code = ST_OK;
    end
  end

  assign contig   = ({15'd0, quot_r} == stride_r);
  assign last_row = (({1'b0, row_r} + 8'd1) == {1'b0, rows_r});

  assign stat.div_done   = (div_cnt_r == DIV_CNT_W'(DIV_STEPS - 1));
  assign stat.out_free   = !out_valid_r || !out_stall;
  assign stat.final_item = (err_code != ST_OK) || contig || last_row;

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      base_r    <= in_base_addr;
      total_r   <= in_total_bytes;
      rows_r    <= in_row_count;
      stride_r  <= in_row_stride;
      quot_r    <= in_total_bytes;
      rem_r     <= '0;
      div_cnt_r <= '0;
      addr_r    <= in_base_addr;
      off_r     <= '0;
      row_r     <= '0;
    end else if (cmd.div_step) begin
      quot_r    <= quot_nxt;
      rem_r     <= rem_nxt;
      div_cnt_r <= div_cnt_r + DIV_CNT_W'(1);
    end else if (cmd.issue) begin
      // advance to the next row
      addr_r <= addr_r + {32'd0, stride_r};
      off_r  <= off_r + quot_r[15:0];
      row_r  <= row_r + 7'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.issue) begin
      if (err_code != ST_OK) begin
        out_addr_r   <= '0;
        out_len_r    <= '0;
        out_off_r    <= '0;
        out_last_r   <= 1'b1;
        out_status_r <= err_code;
      end else if (contig) begin
        out_addr_r   <= base_r;
        out_len_r    <= total_r;
        out_off_r    <= '0;
        out_last_r   <= 1'b1;
        out_status_r <= ST_OK;
      end else begin
        out_addr_r   <= addr_r;
        out_len_r    <= quot_r;
        out_off_r    <= off_r;
        out_last_r   <= last_row;
        out_status_r <= ST_OK;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.issue) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  assign out_valid       = out_valid_r;
  assign out_read_addr   = out_addr_r;
  assign out_read_len    = out_len_r;
  assign out_pack_offset = out_off_r;
  assign out_last        = out_last_r;
  assign out_status      = out_status_r;

  a_issue_needs_room: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.issue |-> (!out_valid_r || !out_stall))
    else $error("request issued over a stalled result");

  a_error_shape: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_status_r != ST_OK) |-> (out_last_r && out_len_r == '0))
    else $error("error result must be a single zero-length final request");

  a_no_issue_in_div: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.div_step |-> !cmd.issue)
    else $error("request issued before the row length was ready");

endmodule
